@@ sv/assert_macros.svh @@
// Assertion macros for the lexer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slx assertion failed");
`define SLX_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("slx assertion failed");
`else
`define SLX_ASSERT(lbl, clk, rst_n, prop)
`define SLX_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/slx_pkg.sv @@
// Shared types and constants for the script lexer.
// No dependencies; imported by every lexer module.
package slx_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int POSITION_BITS = 16;
    localparam int MAX_RESULTS   = 3;
    localparam int KEYWORD_MAX   = 8;

    typedef enum logic [1:0] {
        RK_TOKEN    = 2'd0,
        RK_FINISHED = 2'd1,
        RK_ERROR    = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_source;
    } slx_in_t;

    typedef struct packed {
        result_kind_t             result_kind;
        logic [5:0]               token_kind;
        logic [OFFSET_BITS-1:0]   start_offset;
        logic [POSITION_BITS-1:0] start_line;
        logic [POSITION_BITS-1:0] start_column;
        logic [POSITION_BITS-1:0] token_length;
        logic                     last_result;
    } slx_result_t;

endpackage

@@ sv/script_lexer_top.sv @@
// Top level of the streaming script lexer.
// Depends on slx_pkg, slx_core and slx_fifo.
//
// The in channel takes one source byte per word with an end flag; the out
// channel returns result words (tokens, a finished marker or an error).
// The cfg port writes the tab step at any edge where cfg_we is high.
// A byte is processed in the cycle it is accepted, and its results are
// written into the result queue; out returns at most one word per cycle.
// One byte is accepted every cycle while the eight-entry result queue has
// room for three results; a byte yields zero to three results, so the
// sustained rate is one byte per cycle when results are sparse and is set
// by the single output port otherwise.
// Reset clears all lexer state and the queue and sets the tab step to 4.
// When the receiver stalls, the queue fills and in_ready drops until
// enough results have been taken.
module script_lexer_top
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  slx_in_t     in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output slx_result_t out_word,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data
);

    logic        step;
    logic [1:0]  res_count;
    slx_result_t res [MAX_RESULTS];

    assign step = in_valid && in_ready;

    slx_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .res_count (res_count),
        .res       (res)
    );

    slx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (res_count),
        .push_data (res),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

@@ sv/slx_core.sv @@
// Lexer state and the single-pass step for one source byte.
// Depends on slx_pkg; produces up to three results per accepted word.
module slx_core
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  slx_in_t     in_word,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    output logic [1:0]  res_count,
    output slx_result_t res [MAX_RESULTS]
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_DEC, M_ZERO, M_HEX0, M_HEX, M_BIN0, M_BIN, M_OCT,
        M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR, M_OP
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic [5:0]               pk;
        logic [OFFSET_BITS-1:0]   toff;
        logic [POSITION_BITS-1:0] tline;
        logic [POSITION_BITS-1:0] tcol;
        logic [POSITION_BITS-1:0] tlen;
        logic [OFFSET_BITS-1:0]   coff;
        logic [POSITION_BITS-1:0] cline;
        logic [POSITION_BITS-1:0] ccol;
        logic [63:0]              kb;
        logic                     err;
    } lex_state_t;

    localparam logic [5:0] TK_IDENT = 6'd0, TK_HEX = 6'd1, TK_BIN = 6'd2, TK_OCT = 6'd3;
    localparam logic [5:0] TK_DEC = 6'd4, TK_LINE = 6'd5, TK_BLOCK = 6'd6, TK_KW = 6'd7;
    localparam logic [5:0] TK_LPAREN = 6'd21, TK_RPAREN = 6'd22, TK_LBRACE = 6'd23;
    localparam logic [5:0] TK_RBRACE = 6'd24, TK_EQEQ = 6'd25, TK_FATARROW = 6'd26;
    localparam logic [5:0] TK_ASSIGN = 6'd27, TK_PLUS = 6'd28, TK_ARROW = 6'd29;
    localparam logic [5:0] TK_MINUS = 6'd30, TK_STAR = 6'd31, TK_SLASH = 6'd32;
    localparam logic [5:0] TK_PERCENT = 6'd33, TK_SHL = 6'd34, TK_LE = 6'd35;
    localparam logic [5:0] TK_LT = 6'd36, TK_SHR = 6'd37, TK_GE = 6'd38, TK_GT = 6'd39;
    localparam logic [5:0] TK_ANDAND = 6'd40, TK_AND = 6'd41, TK_OROR = 6'd42;
    localparam logic [5:0] TK_OR = 6'd43, TK_XOR = 6'd44, TK_TILDE = 6'd45;
    localparam logic [5:0] TK_NE = 6'd46, TK_NOT = 6'd47, TK_COLON = 6'd48;
    localparam logic [5:0] TK_SEMI = 6'd49, TK_DOT = 6'd50, TK_COMMA = 6'd51;

    localparam logic [63:0] KW_WORDS [14] = '{
        64'h6669, 64'h65736C65, 64'h74656C, 64'h74736E6F63, 64'h746E49,
        64'h746E6955, 64'h6C6F6F42, 64'h6B61657262, 64'h65756E69746E6F63,
        64'h6E7275746572, 64'h6E6F6974636E7566, 64'h65757274, 64'h65736C6166,
        64'h7365726975716572
    };

    localparam logic [3:0] TAB_RESET = 4'd4;

    lex_state_t st_reg, st_next;
    logic [3:0] tab_reg;

    function automatic logic [POSITION_BITS-1:0] sat_pos(
        input logic [POSITION_BITS-1:0] a, input logic [POSITION_BITS-1:0] b);
        logic [POSITION_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic logic is_bin(input logic [7:0] c);
        return c == "0" || c == "1";
    endfunction

    function automatic logic [5:0] keyword_kind(input lex_state_t s);
        logic [5:0] k;
        k = TK_IDENT;
        if (s.tlen <= POSITION_BITS'(KEYWORD_MAX))
        begin
            for (int i = 0; i < 14; i++)
            begin
                if (KW_WORDS[i] == s.kb)
                begin
                    k = TK_KW + 6'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "+":     k = TK_PLUS;
            "*":     k = TK_STAR;
            "%":     k = TK_PERCENT;
            "^":     k = TK_XOR;
            "~":     k = TK_TILDE;
            ":":     k = TK_COLON;
            ";":     k = TK_SEMI;
            ".":     k = TK_DOT;
            ",":     k = TK_COMMA;
            default: k = TK_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_op(input logic [5:0] first, input logic [7:0] c);
        logic [5:0] k;
        k = TK_IDENT;
        unique case (first)
            TK_ASSIGN: k = (c == "=") ? TK_EQEQ : (c == ">") ? TK_FATARROW : TK_IDENT;
            TK_MINUS:  k = (c == ">") ? TK_ARROW : TK_IDENT;
            TK_LT:     k = (c == "<") ? TK_SHL : (c == "=") ? TK_LE : TK_IDENT;
            TK_GT:     k = (c == ">") ? TK_SHR : (c == "=") ? TK_GE : TK_IDENT;
            TK_AND:    k = (c == "&") ? TK_ANDAND : TK_IDENT;
            TK_OR:     k = (c == "|") ? TK_OROR : TK_IDENT;
            TK_NOT:    k = (c == "=") ? TK_NE : TK_IDENT;
            default:   k = TK_IDENT;
        endcase
        return k;
    endfunction

    function automatic slx_result_t tok_res(input lex_state_t s);
        slx_result_t r;
        r.result_kind  = RK_TOKEN;
        r.token_kind   = (s.mode == M_IDENT) ? keyword_kind(s) : s.pk;
        r.start_offset = s.toff;
        r.start_line   = s.tline;
        r.start_column = s.tcol;
        r.token_length = s.tlen;
        r.last_result  = 1'b0;
        return r;
    endfunction

    function automatic lex_state_t tok_after(input lex_state_t s);
        lex_state_t t;
        t       = s;
        t.cline = s.tline;
        t.ccol  = sat_pos(s.tcol, s.tlen);
        t.mode  = M_IDLE;
        return t;
    endfunction

    function automatic slx_result_t mk_res(input result_kind_t rk,
        input logic [OFFSET_BITS-1:0] off, input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col);
        slx_result_t r;
        r.result_kind  = rk;
        r.token_kind   = TK_IDENT;
        r.start_offset = off;
        r.start_line   = line;
        r.start_column = col;
        r.token_length = '0;
        r.last_result  = 1'b1;
        return r;
    endfunction

    function automatic lex_state_t tok_begin(input lex_state_t s, input mode_t m,
        input logic [5:0] k);
        lex_state_t t;
        t       = s;
        t.toff  = s.coff;
        t.tline = s.cline;
        t.tcol  = s.ccol;
        t.tlen  = POSITION_BITS'(1);
        t.mode  = m;
        t.pk    = k;
        return t;
    endfunction

    always_comb
    begin
        lex_state_t  s;
        logic [7:0]  c;
        logic        eos;
        logic        used;
        logic [1:0]  n;
        logic [5:0]  k;
        slx_result_t r [MAX_RESULTS];
        s    = st_reg;
        c    = in_word.char_in;
        eos  = in_word.end_of_source;
        used = 1'b0;
        n    = '0;
        k    = TK_IDENT;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            r[i] = '0;
        end
        if (s.err)
        begin
            if (eos)
            begin
                s = '0;
            end
        end
        else
        begin
            unique case (s.mode)
                M_IDENT:
                    if (is_alpha(c) || is_decimal(c))
                    begin
                        if (s.tlen < POSITION_BITS'(KEYWORD_MAX))
                        begin
                            s.kb[8*s.tlen[2:0] +: 8] = s.kb[8*s.tlen[2:0] +: 8] | c;
                        end
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                    else
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                M_DEC, M_HEX, M_BIN, M_OCT:
                    if ((s.mode == M_DEC && is_decimal(c)) || (s.mode == M_HEX && is_hex(c))
                        || (s.mode == M_BIN && is_bin(c)) || (s.mode == M_OCT && is_oct(c)))
                    begin
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                    else
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                M_ZERO:
                    if (c == "x" || c == "b" || is_oct(c))
                    begin
                        s.mode = (c == "x") ? M_HEX0 : (c == "b") ? M_BIN0 : M_OCT;
                        s.pk   = (c == "x") ? TK_HEX : (c == "b") ? TK_BIN : s.pk;
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                    else
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                M_HEX0, M_BIN0:
                begin
                    if ((s.mode == M_HEX0) ? is_hex(c) : is_bin(c))
                    begin
                        s.mode = (s.mode == M_HEX0) ? M_HEX : M_BIN;
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                    end
                    else
                    begin
                        r[n] = mk_res(RK_ERROR, s.toff, s.tline, s.tcol); n = n + 2'd1;
                        s.err = 1'b1; s.mode = M_IDLE;
                    end
                    used = 1'b1;
                end
                M_SLASH:
                    if (c == "/" || c == "*")
                    begin
                        s.mode = (c == "/") ? M_LINE : M_BLOCK;
                        s.pk   = (c == "/") ? TK_LINE : TK_BLOCK;
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                    else
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                M_LINE:
                    if (c == "\n")
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                    else
                    begin
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                M_BLOCK:
                begin
                    s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                    if (c == "*")
                    begin
                        s.mode = M_BLOCK_STAR;
                    end
                    used = 1'b1;
                end
                M_BLOCK_STAR:
                begin
                    s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                    if (c == "/")
                    begin
                        r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                    end
                    else if (c != "*")
                    begin
                        s.mode = M_BLOCK;
                    end
                    used = 1'b1;
                end
                M_OP:
                begin
                    k = pair_op(s.pk, c);
                    if (k != TK_IDENT)
                    begin
                        s.pk   = k;
                        s.tlen = sat_pos(s.tlen, POSITION_BITS'(1));
                        used   = 1'b1;
                    end
                    r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                end
                default:
                    s.mode = M_IDLE;
            endcase

            if (!used && !s.err)
            begin
                priority if (c == " ")
                    s.ccol = sat_pos(s.ccol, POSITION_BITS'(1));
                else if (c == "\t")
                    s.ccol = sat_pos(s.ccol, POSITION_BITS'(tab_reg));
                else if (c == "\r")
                    s.ccol = '0;
                else if (c == "\n")
                begin
                    s.ccol  = '0;
                    s.cline = sat_pos(s.cline, POSITION_BITS'(1));
                end
                else if (c == "=") s = tok_begin(s, M_OP, TK_ASSIGN);
                else if (c == "-") s = tok_begin(s, M_OP, TK_MINUS);
                else if (c == "<") s = tok_begin(s, M_OP, TK_LT);
                else if (c == ">") s = tok_begin(s, M_OP, TK_GT);
                else if (c == "&") s = tok_begin(s, M_OP, TK_AND);
                else if (c == "|") s = tok_begin(s, M_OP, TK_OR);
                else if (c == "!") s = tok_begin(s, M_OP, TK_NOT);
                else if (c == "/") s = tok_begin(s, M_SLASH, TK_SLASH);
                else if (c == "0") s = tok_begin(s, M_ZERO, TK_OCT);
                else if (is_alpha(c))
                begin
                    s    = tok_begin(s, M_IDENT, TK_IDENT);
                    s.kb = {56'd0, c};
                end
                else if (is_decimal(c)) s = tok_begin(s, M_DEC, TK_DEC);
                else if (single_op(c) != TK_IDENT)
                begin
                    s    = tok_begin(s, M_OP, single_op(c));
                    r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                end
                else
                begin
                    r[n] = mk_res(RK_ERROR, s.coff, s.cline, s.ccol); n = n + 2'd1;
                    s.err = 1'b1; s.mode = M_IDLE;
                end
            end
            s.coff = (s.coff == '1) ? s.coff : s.coff + OFFSET_BITS'(1);

            if (eos)
            begin
                if (!s.err)
                begin
                    unique case (s.mode)
                        M_IDLE: ;
                        M_HEX0, M_BIN0, M_BLOCK, M_BLOCK_STAR:
                        begin
                            r[n] = mk_res(RK_ERROR, s.toff, s.tline, s.tcol); n = n + 2'd1;
                            s.err = 1'b1; s.mode = M_IDLE;
                        end
                        default:
                        begin
                            if (s.mode == M_ZERO)
                            begin
                                s.pk = TK_DEC;
                            end
                            r[n] = tok_res(s); n = n + 2'd1; s = tok_after(s);
                        end
                    endcase
                end
                if (!s.err)
                begin
                    r[n] = mk_res(RK_FINISHED, s.coff, s.cline, s.ccol); n = n + 2'd1;
                end
                s = '0;
            end
        end
        st_next   = s;
        res       = r;
        res_count = step ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            tab_reg <= TAB_RESET;
        end
        else
        begin
            if (step)
            begin
                st_reg <= st_next;
            end
            if (cfg_we)
            begin
                tab_reg <= cfg_data;
            end
        end
    end

endmodule

@@ sv/slx_fifo.sv @@
// Result queue: takes up to three results a cycle, delivers one a cycle while out_ready is high.
// Depends on slx_pkg and assert_macros.svh.
`include "assert_macros.svh"
module slx_fifo
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_n,
    input  slx_result_t push_data [MAX_RESULTS],
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output slx_result_t out_word
);

    localparam int DEPTH = 8;
    localparam int AW    = $clog2(DEPTH);

    slx_result_t     mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     count_reg, count_next;
    logic            pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = count_reg != '0;
    assign out_word   = mem[rp_reg];
    assign room       = count_reg <= (AW+1)'(DEPTH - MAX_RESULTS);
    assign count_next = count_reg + (AW+1)'(push_n) - (AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                mem[AW'(wp_reg + AW'(i))] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + AW'(push_n);
            rp_reg    <= rp_reg + AW'(pop);
            count_reg <= count_next;
        end
    end

    `SLX_ASSERT(a_no_overflow, clk, rst_n, count_reg <= (AW+1)'(DEPTH))
    `SLX_ASSERT(a_push_needs_room, clk, rst_n, (push_n != 2'd0) |-> room)
    `SLX_ASSERT(a_pop_only_drains, clk, rst_n, (pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule

@@ tb/tb_script_lexer_top.sv @@
// Self-checking testbench for the streaming script lexer top level.
// Depends on slx_pkg and script_lexer_top; a built-in predictor checks every result word.
module tb_script_lexer_top;
    import slx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] OFF_SAT = 24'hFFFFFF;
    localparam logic [15:0] POS_SAT = 16'hFFFF;
    localparam int          CYCLE_LIMIT = 400000;

    typedef enum int {
        LX_IDLE, LX_IDENT, LX_DEC, LX_ZERO, LX_HEX0, LX_HEX, LX_BIN0, LX_BIN,
        LX_OCT, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_OP
    } lex_mode_t;

    localparam logic [5:0] TK_IDENT = 6'd0, TK_HEX = 6'd1, TK_BIN = 6'd2, TK_OCT = 6'd3,
        TK_DEC = 6'd4, TK_LINE_CMT = 6'd5, TK_BLOCK_CMT = 6'd6, TK_KW_FIRST = 6'd7,
        TK_LPAREN = 6'd21, TK_RPAREN = 6'd22, TK_LBRACE = 6'd23, TK_RBRACE = 6'd24,
        TK_EQEQ = 6'd25, TK_ARROW2 = 6'd26, TK_ASSIGN = 6'd27, TK_PLUS = 6'd28,
        TK_ARROW = 6'd29, TK_MINUS = 6'd30, TK_STAR = 6'd31, TK_SLASH = 6'd32,
        TK_PERCENT = 6'd33, TK_SHL = 6'd34, TK_LE = 6'd35, TK_LT = 6'd36, TK_SHR = 6'd37,
        TK_GE = 6'd38, TK_GT = 6'd39, TK_ANDAND = 6'd40, TK_AND = 6'd41, TK_OROR = 6'd42,
        TK_OR = 6'd43, TK_XOR = 6'd44, TK_TILDE = 6'd45, TK_NE = 6'd46, TK_BANG = 6'd47,
        TK_COLON = 6'd48, TK_SEMI = 6'd49, TK_DOT = 6'd50, TK_COMMA = 6'd51;

    class lexer_scoreboard;
        slx_result_t pending_q[$];
        int          fails;
        logic [3:0]  tab_step;
        lex_mode_t   mode;
        logic [5:0]  kind;
        logic [23:0] tok_off, cur_off;
        logic [15:0] tok_line, tok_col, tok_len, cur_line, cur_col;
        logic [63:0] kw_buf;
        bit          err_seen;

        function new();
            fails = 0;
            tab_step = 4'd4;
            clear_state();
        endfunction

        function void clear_state();
            mode = LX_IDLE;
            kind = 0;
            tok_off = 0; tok_line = 0; tok_col = 0; tok_len = 0;
            cur_off = 0; cur_line = 0; cur_col = 0;
            kw_buf = 0;
            err_seen = 0;
        endfunction

        function logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = a + b;
            return s[16] ? POS_SAT : s[15:0];
        endfunction

        function void push(result_kind_t rk, logic [5:0] tk, logic [23:0] off,
                           logic [15:0] ln, logic [15:0] col, logic [15:0] len, logic last);
            slx_result_t r;
            r.result_kind = rk; r.token_kind = tk; r.start_offset = off;
            r.start_line = ln; r.start_column = col; r.token_length = len;
            r.last_result = last;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function logic [5:0] keyword_of();
            string words[14];
            logic [63:0] packed_word;
            words = '{"if", "else", "let", "const", "Int", "Uint", "Bool", "break",
                      "continue", "return", "function", "true", "false", "requires"};
            if (tok_len > 8) return TK_IDENT;
            for (int k = 0; k < 14; k++) begin
                packed_word = 0;
                for (int i = 0; i < words[k].len(); i++)
                    packed_word[8*i +: 8] = words[k][i];
                if (packed_word == kw_buf) return TK_KW_FIRST + 6'(k);
            end
            return TK_IDENT;
        endfunction

        function void emit_token();
            logic [5:0] tk;
            tk = (mode == LX_IDENT) ? keyword_of() : kind;
            push(RK_TOKEN, tk, tok_off, tok_line, tok_col, tok_len, 1'b0);
            cur_line = tok_line;
            cur_col = sat16(tok_col, tok_len);
            mode = LX_IDLE;
        endfunction

        function void emit_error(logic [23:0] off, logic [15:0] ln, logic [15:0] col);
            err_seen = 1;
            mode = LX_IDLE;
            push(RK_ERROR, TK_IDENT, off, ln, col, 16'd0, 1'b1);
        endfunction

        function void start_token(lex_mode_t m, logic [5:0] k);
            tok_off = cur_off; tok_line = cur_line; tok_col = cur_col;
            tok_len = 1; mode = m; kind = k;
        endfunction

        function logic [5:0] single_kind(byte unsigned c);
            case (c)
                "(": return TK_LPAREN;   ")": return TK_RPAREN;
                "{": return TK_LBRACE;   "}": return TK_RBRACE;
                "+": return TK_PLUS;     "*": return TK_STAR;
                "%": return TK_PERCENT;  "^": return TK_XOR;
                "~": return TK_TILDE;    ":": return TK_COLON;
                ";": return TK_SEMI;     ".": return TK_DOT;
                ",": return TK_COMMA;
                default: return 6'd0;
            endcase
        endfunction

        function logic [5:0] pair_kind(logic [5:0] first, byte unsigned c);
            case (first)
                TK_ASSIGN: return c == "=" ? TK_EQEQ : c == ">" ? TK_ARROW2 : 6'd0;
                TK_MINUS:  return c == ">" ? TK_ARROW : 6'd0;
                TK_LT:     return c == "<" ? TK_SHL : c == "=" ? TK_LE : 6'd0;
                TK_GT:     return c == ">" ? TK_SHR : c == "=" ? TK_GE : 6'd0;
                TK_AND:    return c == "&" ? TK_ANDAND : 6'd0;
                TK_OR:     return c == "|" ? TK_OROR : 6'd0;
                TK_BANG:   return c == "=" ? TK_NE : 6'd0;
                default:   return 6'd0;
            endcase
        endfunction

        function bit is_dig(byte unsigned c); return c >= "0" && c <= "9"; endfunction
        function bit is_alf(byte unsigned c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction
        function bit is_hexd(byte unsigned c);
            return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function void idle_char(byte unsigned c);
            logic [5:0] k;
            case (c)
                " ":  begin cur_col = sat16(cur_col, 16'd1); return; end
                "\t": begin cur_col = sat16(cur_col, {12'd0, tab_step}); return; end
                "\r": begin cur_col = 0; return; end
                "\n": begin cur_col = 0; cur_line = sat16(cur_line, 16'd1); return; end
                "=": begin start_token(LX_OP, TK_ASSIGN); return; end
                "-": begin start_token(LX_OP, TK_MINUS); return; end
                "<": begin start_token(LX_OP, TK_LT); return; end
                ">": begin start_token(LX_OP, TK_GT); return; end
                "&": begin start_token(LX_OP, TK_AND); return; end
                "|": begin start_token(LX_OP, TK_OR); return; end
                "!": begin start_token(LX_OP, TK_BANG); return; end
                "/": begin start_token(LX_SLASH, TK_SLASH); return; end
                "0": begin start_token(LX_ZERO, TK_OCT); return; end
                default: ;
            endcase
            if (is_alf(c)) begin
                start_token(LX_IDENT, TK_IDENT);
                kw_buf = {56'd0, c};
                return;
            end
            if (is_dig(c)) begin
                start_token(LX_DEC, TK_DEC);
                return;
            end
            k = single_kind(c);
            if (k != 0) begin
                start_token(LX_OP, k);
                emit_token();
                return;
            end
            emit_error(cur_off, cur_line, cur_col);
        endfunction

        function void note_input(slx_in_t w);
            byte unsigned c;
            bit used;
            logic [5:0] k;
            c = w.char_in;
            used = 0;
            if (err_seen) begin
                if (w.end_of_source) clear_state();
                return;
            end
            case (mode)
                LX_IDENT:
                    if (is_alf(c) || is_dig(c)) begin
                        if (tok_len < 8) kw_buf[8*tok_len[2:0] +: 8] = c;
                        tok_len = sat16(tok_len, 16'd1); used = 1;
                    end else emit_token();
                LX_DEC:
                    if (is_dig(c)) begin tok_len = sat16(tok_len, 16'd1); used = 1; end
                    else emit_token();
                LX_ZERO:
                    if (c == "x") begin
                        mode = LX_HEX0; kind = TK_HEX; tok_len = sat16(tok_len, 16'd1);
                        used = 1;
                    end else if (c == "b") begin
                        mode = LX_BIN0; kind = TK_BIN; tok_len = sat16(tok_len, 16'd1);
                        used = 1;
                    end else if (c >= "0" && c <= "7") begin
                        mode = LX_OCT; tok_len = sat16(tok_len, 16'd1); used = 1;
                    end else emit_token();
                LX_HEX0, LX_BIN0: begin
                    if (mode == LX_HEX0 ? is_hexd(c) : (c == "0" || c == "1")) begin
                        mode = (mode == LX_HEX0) ? LX_HEX : LX_BIN;
                        tok_len = sat16(tok_len, 16'd1);
                    end else emit_error(tok_off, tok_line, tok_col);
                    used = 1;
                end
                LX_HEX:
                    if (is_hexd(c)) begin tok_len = sat16(tok_len, 16'd1); used = 1; end
                    else emit_token();
                LX_BIN:
                    if (c == "0" || c == "1") begin
                        tok_len = sat16(tok_len, 16'd1); used = 1;
                    end else emit_token();
                LX_OCT:
                    if (c >= "0" && c <= "7") begin
                        tok_len = sat16(tok_len, 16'd1); used = 1;
                    end else emit_token();
                LX_SLASH:
                    if (c == "/") begin
                        mode = LX_LINE; kind = TK_LINE_CMT; tok_len = sat16(tok_len, 16'd1);
                        used = 1;
                    end else if (c == "*") begin
                        mode = LX_BLOCK; kind = TK_BLOCK_CMT;
                        tok_len = sat16(tok_len, 16'd1); used = 1;
                    end else emit_token();
                LX_LINE:
                    if (c == "\n") emit_token();
                    else begin tok_len = sat16(tok_len, 16'd1); used = 1; end
                LX_BLOCK: begin
                    tok_len = sat16(tok_len, 16'd1);
                    if (c == "*") mode = LX_BLOCK_STAR;
                    used = 1;
                end
                LX_BLOCK_STAR: begin
                    tok_len = sat16(tok_len, 16'd1);
                    if (c == "/") emit_token();
                    else if (c != "*") mode = LX_BLOCK;
                    used = 1;
                end
                LX_OP: begin
                    k = pair_kind(kind, c);
                    if (k != 0) begin
                        kind = k; tok_len = sat16(tok_len, 16'd1); emit_token(); used = 1;
                    end else emit_token();
                end
                default: mode = LX_IDLE;
            endcase
            if (!used && !err_seen) idle_char(c);
            if (cur_off != OFF_SAT) cur_off = cur_off + 24'd1;
            if (w.end_of_source) begin
                if (!err_seen) begin
                    case (mode)
                        LX_IDLE: ;
                        LX_ZERO: begin kind = TK_DEC; emit_token(); end
                        LX_HEX0, LX_BIN0, LX_BLOCK, LX_BLOCK_STAR:
                            emit_error(tok_off, tok_line, tok_col);
                        default: emit_token();
                    endcase
                end
                if (!err_seen)
                    push(RK_FINISHED, TK_IDENT, cur_off, cur_line, cur_col, 16'd0, 1'b1);
                clear_state();
            end
        endfunction

        function void check_result(slx_result_t got);
            slx_result_t exp;
            if (pending_q.size() == 0) begin
                $error("unexpected result word %p", got);
                fails++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.result_kind !== exp.result_kind) begin
                $error("result_kind: expected %0d, got %0d", exp.result_kind, got.result_kind);
                fails++;
            end
            if (got.token_kind !== exp.token_kind) begin
                $error("token_kind: expected %0d, got %0d", exp.token_kind, got.token_kind);
                fails++;
            end
            if (got.start_offset !== exp.start_offset) begin
                $error("start_offset: expected %0d, got %0d", exp.start_offset, got.start_offset);
                fails++;
            end
            if (got.start_line !== exp.start_line) begin
                $error("start_line: expected %0d, got %0d", exp.start_line, got.start_line);
                fails++;
            end
            if (got.start_column !== exp.start_column) begin
                $error("start_column: expected %0d, got %0d", exp.start_column, got.start_column);
                fails++;
            end
            if (got.token_length !== exp.token_length) begin
                $error("token_length: expected %0d, got %0d", exp.token_length, got.token_length);
                fails++;
            end
            if (got.last_result !== exp.last_result) begin
                $error("last_result: expected %0d, got %0d", exp.last_result, got.last_result);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    slx_in_t     in_word;
    logic        out_valid;
    logic        out_ready;
    slx_result_t out_word;
    logic        cfg_we;
    logic [3:0]  cfg_data;

    lexer_scoreboard results_sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cycle_count;
    int          sent_words;
    string       snippets[$];

    script_lexer_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("script_lexer_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) results_sb.note_input(in_word);
            if (out_valid && out_ready) results_sb.check_result(out_word);
            if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_char(byte unsigned c, bit eos);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word.char_in <= c;
        in_word.end_of_source <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_words++;
    endtask

    task automatic send_text(string s, bit eos);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eos && (i == s.len() - 1));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tab(logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        results_sb.tab_step = v;
    endtask

    task automatic send_random_source();
        int n;
        int pick;
        string ws;
        ws = " \t\r\n";
        n = $urandom_range(6, 1);
        for (int t = 0; t < n; t++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_text(snippets[$urandom_range(snippets.size() - 1)], 0);
            else if (pick < 85)
                send_char(ws[$urandom_range(3)], 0);
            else
                send_char(8'($urandom_range(255)), 0);
        end
        send_char(snippets[0][$urandom_range(snippets[0].len() - 1)], 1);
    endtask

    initial
    begin
        results_sb = new();
        snippets = '{"a0 ", "if ", "else ", "let x=", "const ", "Int ", "Uint ", "Bool ",
                     "break;", "continue ", "return ", "function(", "true ", "false ",
                     "requires ", "0x1F ", "0b101 ", "017 ", "08", "123 ", "// hi\n",
                     "/* c\n* */", "== ", "=> ", "-> ", "<< ", "<= ", ">> ", ">= ", "&& ",
                     "||", "!= ", "{}", "()+*%^~:;.,", "< ", "& | ! - = > ", "\t",
                     "continues ", "_Z9 "};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        cycle_count = 0;
        sent_words = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("if else let const Int Uint Bool\tbreak continue\n", 0);
        send_text("return function true false requires x_y9 ", 1);
        send_text("0x0fF 0b10 0777 08 9 /* a**/ // c\n", 1);
        send_text("== => = + -> - * / % << <= < >> >= > && & || | ^ ~ != ! : ; . ,<", 1);
        send_text("0", 1);
        send_text("0x", 1);
        send_text("0bz", 0);
        send_text("more ignored", 1);
        send_text("/* open *", 1);
        send_text("a\r\n @", 1);
        send_char(8'hFF, 1);
        send_char(8'h80, 0);
        send_char(8'h7F, 1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 51 : 0;
            recv_stall_pct = (phase == 0) ? 51 : (phase == 1) ? 30 : 0;
            write_tab(phase == 0 ? 4'd0 : phase == 1 ? 4'd15 : 4'($urandom_range(8, 1)));
            send_text("\t\tz", 1);
            while (sent_words < 235 + phase * 12) begin
                send_random_source();
                if ($urandom_range(9) == 0) drain();
            end
            drain();
        end
        write_tab(4'd1);
        send_text("\tq", 1);
        drain();
        write_tab(4'd8);
        send_text("\tq", 1);
        drain();
        repeat (10) @(posedge clk);

        if (results_sb.fails == 0 && results_sb.pending_q.size() == 0)
            $display("script_lexer_top regression: pass");
        else
            $display("script_lexer_top regression: fail");
        $finish;
    end
endmodule
